// ----- rtl/core/json_string_escaper_assert.svh -----
// Assertion macros for the JSON string escaper.
// Both sample on the rising edge of clk and are off while rst is high.
`ifndef JSON_STRING_ESCAPER_ASSERT_SVH
`define JSON_STRING_ESCAPER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/jse_pkg.sv -----
`default_nettype none

package jse_pkg;

  // Input transaction
  typedef struct packed {
    logic [7:0]  text_byte;
    logic        first_of_string;
    logic [15:0] start_offset;
  } in_t;

  // Output transaction
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] out_position;
    logic        byte_valid;
    logic        last_of_run;
    logic [15:0] fill_after;
  } out_t;

  // How one input byte is expanded
  typedef enum logic [1:0] {
    KIND_DROP,
    KIND_PLAIN,
    KIND_ESC2,
    KIND_HEX6
  } kind_t;

  // Work item passed from the classifier to the emitter
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;        // plain byte, escape letter, or control byte
    logic [15:0] position;    // fill position before this byte
    logic [15:0] fill_after;  // fill position after this byte
  } entry_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // Number of output bytes for each kind (a drop still yields one report)
  function automatic logic [2:0] kind_len(input kind_t kind);
    logic [2:0] len;
    unique case (kind)
      KIND_DROP:  len = 3'd1;
      KIND_PLAIN: len = 3'd1;
      KIND_ESC2:  len = 3'd2;
      KIND_HEX6:  len = 3'd6;
      default:    len = 3'd1;
    endcase
    return len;
  endfunction

  // Lowercase hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + {4'd0, nib};
    end else begin
      ch = CH_A + {4'd0, nib - 4'd10};
    end
    return ch;
  endfunction

  // Byte number idx of the escaped form of an entry
  function automatic logic [7:0] seq_byte(input entry_t e, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (e.kind)
      KIND_DROP:  ch = 8'h00;
      KIND_PLAIN: ch = e.data;
      KIND_ESC2:  ch = (idx == 3'd0) ? CH_BSLASH : e.data;
      KIND_HEX6: begin
        case (idx)
          3'd0:    ch = CH_BSLASH;
          3'd1:    ch = CH_U;
          3'd2:    ch = CH_ZERO;
          3'd3:    ch = CH_ZERO;
          3'd4:    ch = hex_digit(e.data[7:4]);
          default: ch = hex_digit(e.data[3:0]);
        endcase
      end
      default:    ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/jse_front.sv -----
`default_nettype none

module jse_front
  import jse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data,
  output logic             push,
  output entry_t           push_entry,
  input  wire logic        q_ready
);

  logic [15:0] buffer_size;
  logic [15:0] fill_count;
  logic [15:0] fill_base;
  logic        room2;
  logic        room6;
  kind_t       kind;
  logic [7:0]  data;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  // Pick the fill position and check capacity without wrap
  always_comb begin
    fill_base = in_data.first_of_string ? in_data.start_offset : fill_count;
    room2 = ({1'b0, fill_base} + 17'd2) < {1'b0, buffer_size};
    room6 = ({1'b0, fill_base} + 17'd6) < {1'b0, buffer_size};
  end

  // Classify the byte
  always_comb begin
    kind = KIND_PLAIN;
    data = in_data.text_byte;
    if (in_data.text_byte == 8'h00 || !room2) begin
      kind = KIND_DROP;
    end else begin
      unique case (in_data.text_byte)
        CH_BSLASH: begin kind = KIND_ESC2; data = CH_BSLASH; end
        CH_QUOTE:  begin kind = KIND_ESC2; data = CH_QUOTE;  end
        CH_LF:     begin kind = KIND_ESC2; data = CH_N;      end
        CH_CR:     begin kind = KIND_ESC2; data = CH_R;      end
        CH_TAB:    begin kind = KIND_ESC2; data = CH_T;      end
        default: begin
          if (in_data.text_byte < CTRL_LIMIT) begin
            kind = room6 ? KIND_HEX6 : KIND_DROP;
          end else begin
            kind = KIND_PLAIN;
          end
        end
      endcase
    end
  end

  // Build the work item
  always_comb begin
    push_entry.kind     = kind;
    push_entry.data     = data;
    push_entry.position = fill_base;
    if (kind == KIND_DROP) begin
      push_entry.fill_after = fill_base;
    end else begin
      push_entry.fill_after = fill_base + {13'd0, kind_len(kind)};
    end
  end

  // Hold the size register and advance the fill position
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= 16'hFFFF;
      fill_count  <= 16'd0;
    end else begin
      if (cfg_write) begin
        buffer_size <= cfg_data;
      end
      if (push) begin
        fill_count <= push_entry.fill_after;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/jse_queue.sv -----
`default_nettype none

module jse_queue
  import jse_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        q_ready,
  input  wire logic   pop,
  output logic        q_valid,
  output entry_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_ready = (count != CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/jse_back.sv -----
`default_nettype none

module jse_back
  import jse_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  input  wire entry_t head,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output out_t        out_data
);

  logic [2:0] beat;
  logic       load;
  logic       last;
  out_t       result;

  assign load = q_valid && (!out_valid || out_ready);
  assign last = (beat == kind_len(head.kind) - 3'd1);
  assign pop  = load && last;

  // Form the next output byte of the head entry
  always_comb begin
    result.fill_after = head.fill_after;
    result.last_of_run = last;
    if (head.kind == KIND_DROP) begin
      result.out_byte     = 8'h00;
      result.out_position = head.position;
      result.byte_valid   = 1'b0;
    end else begin
      result.out_byte     = seq_byte(head, beat);
      result.out_position = head.position + {13'd0, beat};
      result.byte_valid   = 1'b1;
    end
  end

  // Load the output register and step through the entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        beat      <= last ? 3'd0 : beat + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/json_string_escaper.sv -----
// Channel   Dir  Handshake               Payload
// in        in   in_valid / in_ready     in_data  (jse_pkg::in_t)
// out       out  out_valid / out_ready   out_data (jse_pkg::out_t)
// cfg       in   cfg_write               cfg_data (buffer size, 16 bits)
//
// A plain byte or a dropped byte yields one output per cycle while out_ready is
// high; a two-byte escape yields two outputs and a \u00xx escape six, issued in
// turn from the emitter's one output register. The classifier runs ahead through
// a small queue, so input stalls only once that queue is full. An accepted byte
// passes through a queue slot, then the output register. Reset (rst, synchronous)
// empties the queue, sets the size to 65535 and the fill position to 0.
`default_nettype none

module json_string_escaper
  import jse_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data
);

  logic   push;
  entry_t push_entry;
  logic   q_ready;
  logic   q_valid;
  logic   pop;
  entry_t head;

  jse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready)
  );

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  jse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `include "json_string_escaper_assert.svh"

  // A dropped byte reports as the only output of its transaction
  `JSE_ASSERT_NOW(a_drop_is_last, out_valid && !out_data.byte_valid, out_data.last_of_run, "dropped byte not marked last")

  // Bytes of one escape go to consecutive positions without a gap
  `JSE_ASSERT_NEXT(a_run_contiguous, out_valid && out_ready && out_data.byte_valid && !out_data.last_of_run, out_valid && out_data.out_position == 16'($past(out_data.out_position) + 16'd1), "escape bytes not contiguous")

  // Fill position after the byte stays the same across its run
  `JSE_ASSERT_NEXT(a_run_fill_same, out_valid && out_ready && !out_data.last_of_run, out_data.fill_after == $past(out_data.fill_after), "fill_after changed within run")

  // The emitter only retires an entry that is present
  `JSE_ASSERT_NOW(a_pop_nonempty, pop, q_valid, "pop from empty queue")

endmodule

`default_nettype wire
